[design/fpa_pkg.sv]
// Package for the 16.16 fixed-point ALU: operation codes, sizes, stage payload types.
// No dependencies.
package fpa_pkg;
	localparam int DataW = 32;
	localparam int QuotW = 48;
	localparam int DivBits = QuotW;
	localparam logic [DataW-1:0] SatPos = 32'h7FFF_FFFF;
	localparam logic [DataW-1:0] SatNeg = 32'h8000_0001;
	localparam logic [15:0] LimitInt = 16'd32767;

	typedef enum logic [2:0] {
		OP_MUL   = 3'd0,
		OP_DIV   = 3'd1,
		OP_ROUND = 3'd2,
		OP_FLOOR = 3'd3,
		OP_FROM  = 3'd4
	} op_t;

	// Item travelling down the divider cell row
	typedef struct packed {
		logic             vld;
		logic             is_div;
		logic             neg;
		logic             done;
		logic [DataW-1:0] fix;
		logic             err;
		logic [QuotW:0]   rem;
		logic [QuotW-1:0] num;
		logic [QuotW-1:0] quo;
		logic [DataW:0]   den;
	} cell_t;
endpackage

[design/fpa_if.sv]
// Valid/ready channel interface for the fixed-point ALU.
// No dependencies.
interface fpa_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	modport source (output valid, operation, operand_a, operand_b, input ready);
	modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] result;
	logic        range_error;
	modport source (output valid, result, range_error, input ready);
	modport sink (input valid, result, range_error, output ready);
endinterface

[design/fpa_front.sv]
// Front stage: decodes the operation, resolves the simple operations and the
// multiply (registered product), and seeds the divider cell row. Uses fpa_pkg.
module fpa_front import fpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [2:0]  op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output cell_t       seed
);
	logic        na, nb;
	logic [31:0] ma, mb;
	logic [63:0] prod_s1;
	logic        mul_s1, mneg_s1;
	cell_t       pre;
	logic [63:0] prod;
	logic        pneg;
	logic [47:0] qlim;
	logic [QuotW:0] dnum;

	assign na = a[31];
	assign nb = b[31];
	assign ma = na ? (~a + 32'd1) : a;
	assign mb = nb ? (~b + 32'd1) : b;
	assign qlim = {16'd0, mb} * {32'd0, LimitInt};
	// Rounding numerator 2*|a|*2^16 + |b|; needs one bit above the row width
	assign dnum = {ma, 17'd0} + {17'd0, mb};

	// Decode and operand prep, first stage
	always_comb begin
		pre = '0;
		pre.vld = in_vld;
		pre.done = 1'b1;
		pre.den = {mb, 1'b0};
		unique case (op)
			OP_DIV: begin
				if (mb == '0) begin
					pre.fix = na ? SatNeg : SatPos;
					pre.err = 1'b1;
				end else if ({16'd0, ma} > qlim) begin
					pre.fix = (na != nb) ? SatNeg : SatPos;
					pre.err = 1'b1;
				end else begin
					pre.is_div = 1'b1;
					pre.done = 1'b0;
					pre.neg = (na != nb) && (ma != '0);
					// Top numerator bit starts in the remainder; its quotient bit is zero
					pre.rem = {{QuotW{1'b0}}, dnum[QuotW]};
					pre.num = dnum[QuotW-1:0];
				end
			end
			OP_ROUND: pre.fix = {{16{a[31]}}, a[31:16]} + {31'd0, a[15]};
			OP_FLOOR: pre.fix = {{16{a[31]}}, a[31:16]};
			OP_FROM:  pre.fix = {a[15:0], 16'd0};
			default:  pre.fix = '0;
		endcase
	end

	// Product register; multiply result finished one stage later
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1 <= 1'b0;
		end else if (en) begin
			mul_s1 <= in_vld && (op == OP_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {32'd0, ma} * {32'd0, mb};
			mneg_s1 <= na != nb;
		end
	end

	cell_t pre_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s1 <= '0;
		end else if (en) begin
			pre_s1 <= pre;
		end
	end

	// Finish the multiply: range check and rounding
	assign prod = prod_s1;
	assign pneg = mneg_s1 && (prod != '0);
	logic [47:0] rnd;
	assign rnd = prod[63:16] + {47'd0, prod[15]};
	always_comb begin
		seed = pre_s1;
		if (mul_s1) begin
			if (prod > {16'd0, LimitInt, 32'd0}) begin
				seed.fix = pneg ? SatNeg : SatPos;
				seed.err = 1'b1;
			end else begin
				seed.fix = pneg ? (~rnd[31:0] + 32'd1) : rnd[31:0];
				seed.err = 1'b0;
			end
		end
	end
endmodule

[design/fpa_cell.sv]
// One restoring-division cell: brings in one numerator bit, trial subtract,
// and hands the item to the next cell. Uses fpa_pkg.
module fpa_cell import fpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cell_t din,
	output cell_t dout
);
	cell_t       nxt;
	logic [QuotW:0] sh;
	logic [QuotW:0] diff;

	// Shift in the next numerator bit and try the subtract
	always_comb begin
		nxt = din;
		sh = {din.rem[QuotW-1:0], din.num[QuotW-1]};
		diff = sh - {{(QuotW-DataW){1'b0}}, din.den};
		nxt.num = {din.num[QuotW-2:0], 1'b0};
		if (din.is_div) begin
			if (!diff[QuotW]) begin
				nxt.rem = diff;
				nxt.quo = {din.quo[QuotW-2:0], 1'b1};
			end else begin
				nxt.rem = sh;
				nxt.quo = {din.quo[QuotW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule

[design/fixed_point_16_16_alu.sv]
// Top level of the signed 16.16 fixed-point ALU: front stage, a row of
// division cells, and the result pick. Uses fpa_pkg, fpa_if, fpa_front, fpa_cell.
//
// channel | dir | payload                          | handshake
// in      | in  | operation, operand_a, operand_b  | valid/ready
// out     | out | result, range_error              | valid/ready
//
// One item enters per clock unless the row stalls; each item passes the front
// product register and then the 48-cell divider row.
// The whole row advances together; it stalls only while a result waits at
// the output and the output side is not ready (ready = out ready or last empty).
// Reset clears all valid bits.
module fixed_point_16_16_alu import fpa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fpa_in_if.sink       in,
	fpa_out_if.source    out
);
	logic  en;
	cell_t chain [DivBits+1];
	cell_t last;

	assign en = out.ready || !last.vld;
	assign in.ready = en;

	fpa_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in.valid),
		.op(in.operation), .a(in.operand_a), .b(in.operand_b), .seed(chain[0])
	);

	// Divider cell row
	for (genvar i = 0; i < DivBits; i++) begin : g_cell
		fpa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .din(chain[i]), .dout(chain[i+1])
		);
	end

	assign last = chain[DivBits];

	// Result pick: quotient with sign or the fixed value
	assign out.valid = last.vld;
	assign out.result = last.done ? last.fix :
		(last.neg ? (~last.quo[31:0] + 32'd1) : last.quo[31:0]);
	assign out.range_error = last.done ? last.err : 1'b0;
endmodule

[tb/fpa_checker.sv]
// Checker for the 16.16 fixed-point ALU: watches both channels, predicts each
// result and compares it with the block's output. Depends on fpa_pkg and fpa_if.
`timescale 1ns / 100ps
module fpa_checker import fpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fpa_in_if.sink     in_mon,
	fpa_out_if.sink    out_mon,
	output int         fail_count,
	output int         pending,
	output int         result_count
);
	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} alu_result_t;

	alu_result_t result_queue[$];

	function automatic logic [63:0] mag32(logic [31:0] v);
		return v[31] ? {32'd0, -v} : {32'd0, v};
	endfunction

	function automatic logic [31:0] signed_of(logic [63:0] m, logic neg);
		logic [31:0] t;
		t = m[31:0];
		return neg ? -t : t;
	endfunction

	// Compute the expected result of one operation
	function automatic alu_result_t alu_predict(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		alu_result_t r;
		logic [63:0] ma, mb, p, q;
		logic        neg;
		logic [31:0] fl;
		ma = mag32(a);
		mb = mag32(b);
		fl = {{16{a[31]}}, a[31:16]};
		r = '0;
		case (op)
			OP_MUL: begin
				p = ma * mb;
				neg = (a[31] != b[31]) && p != 0;
				if (p > (64'd32767 << 32)) begin
					r.value = neg ? SatNeg : SatPos;
					r.sat = 1'b1;
				end else
					r.value = signed_of((p + 64'h8000) >> 16, neg);
			end
			OP_DIV: begin
				if (mb == 0) begin
					r.value = a[31] ? SatNeg : SatPos;
					r.sat = 1'b1;
				end else begin
					neg = (a[31] != b[31]) && ma != 0;
					if (ma > 64'd32767 * mb) begin
						r.value = neg ? SatNeg : SatPos;
						r.sat = 1'b1;
					end else begin
						q = ((ma << 17) + mb) / (mb << 1);
						r.value = signed_of(q, neg);
					end
				end
			end
			OP_ROUND: r.value = fl + {31'd0, a[15]};
			OP_FLOOR: r.value = fl;
			OP_FROM:  r.value = a << 16;
			default:  r = '0;
		endcase
		return r;
	endfunction

	assign pending = result_queue.size();

	// Predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		alu_result_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				result_queue.push_back(alu_predict(in_mon.operation, in_mon.operand_a,
					in_mon.operand_b));
			if (out_mon.valid && out_mon.ready) begin
				result_count <= result_count + 1;
				if (result_queue.size() == 0) begin
					$error("unexpected result %h", out_mon.result);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = result_queue.pop_front();
					if (out_mon.result !== exp_r.value) begin
						$error("result: expected %h actual %h", exp_r.value, out_mon.result);
						fail_count <= fail_count + 1;
					end
					if (out_mon.range_error !== exp_r.sat) begin
						$error("range_error: expected %b actual %b", exp_r.sat,
							out_mon.range_error);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[tb/tb_top.sv]
// Top of the 16.16 fixed-point ALU testbench: clock, reset, stimulus, verdict.
// Depends on fpa_pkg, fpa_if, fpa_checker and the ALU.
`timescale 1ns / 100ps
module tb_top;
	import fpa_pkg::*;

	localparam int NumRandom = 1880;
	localparam int DrainCycles = 120;

	logic clk;
	logic arst_n;
	int   fail_count, pending, result_count;
	int   hold_cycles;

	fpa_in_if  in_ch();
	fpa_out_if out_ch();

	fixed_point_16_16_alu DUT (.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source));

	fpa_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {{16{1'b0}}, 16'($urandom)};
			2: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
			3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
			4: return 32'($signed($urandom_range(0, 4))) << 16;
			default: return {1'b0, 31'($urandom)} >> $urandom_range(0, 31);
		endcase
	endfunction

	// Offer one item and wait for its transfer
	task automatic send_op(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		int g;
		g = gap_len();
		repeat (g) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// Receiver: random stalls, and one long hold-off early in the random part
	initial begin
		int g;
		out_ch.ready = 1'b0;
		hold_cycles = 0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			g = gap_len();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		logic [2:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		int          wait_cnt;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_MUL;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, each operation, saturation edges, zero divisor, unused codes
		send_op(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_op(OP_MUL, 32'h7FFF_0000, 32'h0001_0000);
		send_op(OP_MUL, 32'h7FFF_0000, 32'hFFFF_0000);
		send_op(OP_MUL, 32'h7FFF_0001, 32'h0001_0000);
		send_op(OP_MUL, 32'h0000_0001, 32'h0000_8000);
		send_op(OP_MUL, 32'hFFFF_FFFF, 32'h0000_8000);
		send_op(OP_MUL, 32'h0000_0000, 32'h8000_0000);
		send_op(OP_DIV, 32'h0001_0000, 32'h0000_0000);
		send_op(OP_DIV, 32'h8000_0000, 32'h0000_0000);
		send_op(OP_DIV, 32'h7FFF_0000, 32'h0001_0000);
		send_op(OP_DIV, 32'h7FFF_0001, 32'h0001_0000);
		send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_op(OP_DIV, 32'h0000_0001, 32'h0002_0000);
		send_op(OP_DIV, 32'hFFFF_FFFF, 32'h8000_0000);
		send_op(OP_DIV, 32'h0000_0000, 32'hFFFF_0000);
		send_op(OP_ROUND, 32'h0001_8000, '0);
		send_op(OP_ROUND, 32'hFFFF_7FFF, '1);
		send_op(OP_ROUND, 32'h8000_0000, '0);
		send_op(OP_FLOOR, 32'h7FFF_FFFF, '0);
		send_op(OP_FLOOR, 32'hFFFF_FFFF, '0);
		send_op(OP_FROM, 32'hFFFF_8001, '0);
		send_op(OP_FROM, 32'h0000_7FFF, '0);
		for (int k = 5; k < 8; k++) send_op(3'(k), $urandom, $urandom);

		// Random part; long receiver hold-off early on to back up the pipeline
		for (int n = 0; n < NumRandom; n++) begin
			if (n == 100) hold_cycles = 300;
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			a = rand_operand();
			b = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_operand();
			send_op(op, a, b);
		end
		in_ch.valid <= 1'b0;

		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (DrainCycles) @(posedge clk);
		$display("Covered all five operations, unused codes, saturation and zero divisors;");
		$display("%0d results checked under random stalls on both sides.", result_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule

[filelist.f]
design/fpa_pkg.sv
design/fpa_if.sv
design/fpa_front.sv
design/fpa_cell.sv
design/fixed_point_16_16_alu.sv
tb/fpa_checker.sv
tb/tb_top.sv
